// ===== hdl/wosc_pkg.sv =====
// Shared types and constants for the waveform oscillator voice.
// No dependencies; used by every module of the block.
`default_nettype none

package wosc_pkg;

    typedef enum logic [1:0] {
        OP_TICK     = 2'd0,
        OP_NOTE_ON  = 2'd1,
        OP_NOTE_OFF = 2'd2,
        OP_SET_FREQ = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        WAVE_SQUARE = 2'd0,
        WAVE_SAW    = 2'd1,
        WAVE_TRI    = 2'd2,
        WAVE_PULSE  = 2'd3
    } t_wave;

    // configuration register indexes
    localparam logic CFG_WAVEFORM     = 1'b0;
    localparam logic CFG_RELEASE_STEP = 1'b1;

    localparam int          AMP_BITS      = 24;
    localparam logic [23:0] AMP_ONE       = 24'h80_0000;
    localparam logic [23:0] RELEASE_RESET = 24'd1268;

    localparam logic signed [16:0] WAVE_PEAK = 17'sd32767;

    // one command from the input register to the voice
    typedef struct packed {
        logic fire;
        t_op  op;
    } t_cmd;

endpackage

`default_nettype wire

// ===== hdl/wosc_wave.sv =====
// Wave shaper: maps the top 16 phase bits to a Q15 square, saw, triangle or pulse value.
// Depends on wosc_pkg.
`default_nettype none

module wosc_wave (
    input  wire logic [15:0]          i_phase,
    input  wosc_pkg::t_wave           i_sel,
    output logic signed [16:0]        o_value
);

    logic signed [16:0] w_saw;
    logic signed [16:0] w_mag;
    logic signed [17:0] w_tri;

    always_comb begin
        // p - 32768 is the phase with its top bit flipped, read as signed
        w_saw = 17'($signed({~i_phase[15], i_phase[14:0]}));
        w_mag = w_saw[16] ? -w_saw : w_saw;
        w_tri = 18'(w_mag) * 18'sd2 - 18'sd32768;
        case (i_sel)
            wosc_pkg::WAVE_SQUARE: o_value = i_phase[15] ? -wosc_pkg::WAVE_PEAK
                                                         : wosc_pkg::WAVE_PEAK;
            wosc_pkg::WAVE_SAW:    o_value = w_saw;
            wosc_pkg::WAVE_TRI:    o_value = w_tri[16:0];
            wosc_pkg::WAVE_PULSE:  o_value = (i_phase[15:14] == 2'b00) ? wosc_pkg::WAVE_PEAK
                                                                       : -wosc_pkg::WAVE_PEAK;
            default:               o_value = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/wosc_voice.sv =====
// Voice state: phase accumulator, step, amplitude and release, plus the sample multiply and clip.
// Depends on wosc_pkg and wosc_wave.
`default_nettype none

module wosc_voice #(
    parameter int PHASE_BITS  = 32,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wosc_pkg::t_cmd                 i_cmd,
    input  wire logic [PHASE_BITS-1:0]     i_step,
    input  wosc_pkg::t_wave                i_waveform,
    input  wire logic [23:0]               i_release_step,
    output logic signed [SAMPLE_BITS-1:0]  o_sample,
    output logic                           o_active
);

    localparam int                SHIFT = 40 - SAMPLE_BITS;
    localparam logic signed [41:0] BIAS = (42'sd1 <<< SHIFT) - 42'sd1;
    localparam logic signed [41:0] SMAX = (42'sd1 <<< (SAMPLE_BITS - 1)) - 42'sd1;

    logic [PHASE_BITS-1:0] r_phase, n_phase;
    logic [PHASE_BITS-1:0] r_step,  n_step;
    logic [23:0]           r_amp,   n_amp;
    logic                  r_playing, n_playing;
    logic                  r_releasing, n_releasing;

    logic                  w_sounding;
    logic [24:0]           w_diff;
    logic signed [16:0]    w_value;
    logic signed [41:0]    w_prod;
    logic signed [41:0]    w_adj;
    logic signed [41:0]    w_quot;
    logic signed [41:0]    w_clip;

    wosc_wave u_wave (
        .i_phase (r_phase[PHASE_BITS-1 -: 16]),
        .i_sel   (i_waveform),
        .o_value (w_value)
    );

    always_comb begin
        w_sounding  = r_playing | r_releasing;
        w_diff      = {1'b0, r_amp} - {1'b0, i_release_step};
        n_phase     = r_phase;
        n_step      = r_step;
        n_amp       = r_amp;
        n_playing   = r_playing;
        n_releasing = r_releasing;
        if (i_cmd.fire) begin
            case (i_cmd.op)
                wosc_pkg::OP_NOTE_ON: begin
                    n_step      = i_step;
                    n_phase     = '0;
                    n_amp       = wosc_pkg::AMP_ONE;
                    n_playing   = 1'b1;
                    n_releasing = 1'b0;
                end
                wosc_pkg::OP_SET_FREQ: begin
                    n_step  = i_step;
                    n_phase = '0;
                end
                wosc_pkg::OP_NOTE_OFF: begin
                    n_releasing = 1'b1;
                end
                wosc_pkg::OP_TICK: begin
                    if (w_sounding) begin
                        n_phase = r_phase + r_step;
                    end
                    // release ends once the difference is zero or negative
                    if (r_releasing) begin
                        if (w_diff[24] || (w_diff == '0)) begin
                            n_amp       = '0;
                            n_playing   = 1'b0;
                            n_releasing = 1'b0;
                        end else begin
                            n_amp = w_diff[23:0];
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // sample from the amplitude before this tick's release step
    always_comb begin
        w_prod = $signed(w_value) * $signed({1'b0, r_amp});
        w_adj  = w_prod + (w_prod[41] ? BIAS : '0);
        w_quot = w_adj >>> SHIFT;
        if (w_quot > SMAX) begin
            w_clip = SMAX;
        end else if (w_quot < -SMAX) begin
            w_clip = -SMAX;
        end else begin
            w_clip = w_quot;
        end
        o_sample = w_sounding ? w_clip[SAMPLE_BITS-1:0] : '0;
        o_active = n_playing | n_releasing;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= '0;
            r_step      <= '0;
            r_amp       <= '0;
            r_playing   <= 1'b0;
            r_releasing <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_step      <= n_step;
            r_amp       <= n_amp;
            r_playing   <= n_playing;
            r_releasing <= n_releasing;
        end
    end

    a_amp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_amp <= wosc_pkg::AMP_ONE)
        else $error("amplitude above full scale");

    a_note_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.fire && (i_cmd.op == wosc_pkg::OP_NOTE_ON))
        |=> (r_amp == wosc_pkg::AMP_ONE) && r_playing && !r_releasing && (r_phase == '0))
        else $error("note on did not start the voice");

    a_idle_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.fire && (i_cmd.op == wosc_pkg::OP_TICK) && !r_playing && !r_releasing)
        |=> $stable(r_phase) && !r_playing)
        else $error("idle tick moved the phase");

endmodule

`default_nettype wire

// ===== hdl/waveform_oscillator_with_release_unit.sv =====
// Top level of the oscillator voice: input word register, configuration registers,
// result register. Depends on wosc_pkg and wosc_voice.
//
//  channel   | direction | word
//  ----------+-----------+------------------------------------------------------
//  s (in)    | slave     | tuser: op[1:0]; tdata: phase_step[31:0]
//  m (out)   | master    | tdata: sample[SAMPLE_BITS-1:0], active, zero fill
//  cfg       | slave     | index 0 waveform[1:0], index 1 release_step[23:0]
//
// One word per cycle sustained unless a tick waits on a full result register; a
// tick's result passes through the input register, then the voice's multiply
// and state update into the result register, before it leaves the output.
// Synchronous active-low reset clears control state and loads the register defaults.
// A stalled output holds its word; the input keeps taking words until a tick
// finds the result register still full.
`default_nettype none

module waveform_oscillator_with_release_unit #(
    parameter int PHASE_BITS  = 32,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // slave side
    input  wire logic                             i_s_tvalid,
    output logic                                  o_s_tready,
    input  wire logic [31:0]                      i_s_tdata,   // phase_step[31:0]
    input  wire logic [1:0]                       i_s_tuser,   // op[1:0]
    // master side
    output logic                                  o_m_tvalid,
    input  wire logic                             i_m_tready,
    output logic [((SAMPLE_BITS+8)/8)*8-1:0]      o_m_tdata,   // sample, active, zeros
    // configuration
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [0:0]                       i_cfg_index,
    input  wire logic [23:0]                      i_cfg_data
);

    localparam int OUT_W = ((SAMPLE_BITS + 8) / 8) * 8;

    logic                         r_in_valid;
    wosc_pkg::t_op                r_in_op;
    logic [PHASE_BITS-1:0]        r_in_step;

    logic                         r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_out_sample;
    logic                         r_out_active;

    wosc_pkg::t_wave              r_waveform;
    logic [23:0]                  r_release_step;

    logic                         w_out_free;
    logic                         w_exec;
    logic                         w_tick;
    wosc_pkg::t_cmd               w_cmd;
    logic signed [SAMPLE_BITS-1:0] w_sample;
    logic                         w_active;

    always_comb begin
        w_out_free = !r_out_valid || i_m_tready;
        w_exec     = r_in_valid && ((r_in_op != wosc_pkg::OP_TICK) || w_out_free);
        w_tick     = w_exec && (r_in_op == wosc_pkg::OP_TICK);
        w_cmd.fire = w_exec;
        w_cmd.op   = r_in_op;
        o_s_tready = !r_in_valid || w_exec;
        o_m_tvalid = r_out_valid;
        o_m_tdata  = OUT_W'({r_out_active, r_out_sample});
        o_cfg_ready = 1'b1;
    end

    wosc_voice #(
        .PHASE_BITS  (PHASE_BITS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_voice (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_step         (r_in_step),
        .i_waveform     (r_waveform),
        .i_release_step (r_release_step),
        .o_sample       (w_sample),
        .o_active       (w_active)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_waveform     <= wosc_pkg::WAVE_SQUARE;
            r_release_step <= wosc_pkg::RELEASE_RESET;
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (w_tick) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    wosc_pkg::CFG_WAVEFORM:     r_waveform     <= wosc_pkg::t_wave'(i_cfg_data[1:0]);
                    wosc_pkg::CFG_RELEASE_STEP: r_release_step <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    // payload words, no reset
    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_op   <= wosc_pkg::t_op'(i_s_tuser);
            // truncate or zero-extend the step to the phase width
            r_in_step <= PHASE_BITS'({{PHASE_BITS{1'b0}}, i_s_tdata});
        end
        if (w_tick) begin
            r_out_sample <= w_sample;
            r_out_active <= w_active;
        end
    end

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> r_in_valid && r_out_valid && !i_m_tready
                        && (r_in_op == wosc_pkg::OP_TICK))
        else $error("input stalled without a blocked tick");

    a_tick_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tick |=> r_out_valid)
        else $error("tick gave no result word");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_exec && (r_in_op != wosc_pkg::OP_TICK) && !r_out_valid) |=> !r_out_valid)
        else $error("non-tick word produced a result");

endmodule

`default_nettype wire
